// ----- hw/rtl/assert_macros.svh -----
// assertion helper macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("%m: lbl");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- hw/rtl/mcv_pkg.sv -----
// ----------------------------------------------------------------------------
// mcv_pkg
// types and constants of the most common value estimator
// ----------------------------------------------------------------------------
package mcv_pkg;
  localparam int unsigned SampleBits = 8;
  localparam int unsigned CountBits  = 21;
  localparam int unsigned NumBins    = 1 << SampleBits;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [24:0] OneQ24 = 25'd16777216;
  localparam logic [31:0] ZQ30 = 32'd2765775655;
  localparam logic [20:0] EntMax = 21'd1572864;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_SHORT = 1'b1
  } status_e;

  typedef struct packed {
    logic [20:0] max_count;
    logic [24:0] p_hat;
    logic [24:0] p_upper;
    logic [20:0] h_min;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } sample_t;

  // start request from histogram to math unit
  typedef struct packed {
    logic                 start;
    logic [CountBits-1:0] max_count;
    logic [CountBits-1:0] total;
  } math_req_t;

  typedef enum logic [2:0] {
    HS_RUN, HS_SCAN, HS_SCAN_END, HS_WAIT, HS_CLEAR
  } hist_state_e;

  typedef enum logic [3:0] {
    MS_IDLE, MS_DIV1, MS_MUL, MS_DIV2, MS_SQRT, MS_ZMUL, MS_NORM, MS_LOG, MS_DONE
  } math_state_e;
endpackage

// ----- hw/rtl/mcv_if.sv -----
// ----------------------------------------------------------------------------
// mcv_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface mcv_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mcv_hist.sv -----
// ----------------------------------------------------------------------------
// mcv_hist
// histogram memory with read-modify-write, max scan and clearing sweep
// ----------------------------------------------------------------------------
module mcv_hist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  mcv_pkg::sample_t   in_data_i,
  output logic               in_ready_o,
  output mcv_pkg::math_req_t req_o,
  input  logic               math_busy_i
);
  import mcv_pkg::*;

  logic [CountBits-1:0] mem [NumBins];
  logic [CountBits-1:0] rd_q;
  hist_state_e state_q, state_d;

  // pipeline of the increment: stage 1 holds address of pending read
  logic                  p_vld_q, p_last_q;
  logic [SampleBits-1:0] p_addr_q;
  // last written entry for forwarding
  logic                  w_vld_q;
  logic [SampleBits-1:0] w_addr_q;
  logic [CountBits-1:0]  w_data_q;
  logic [CountBits-1:0]  total_q, max_q;
  logic [SampleBits:0]   ptr_q, ptr_d;

  logic                  acc;
  logic [SampleBits-1:0] rd_addr;
  logic                  we;
  logic [SampleBits-1:0] wa;
  logic [CountBits-1:0]  wd, cur;

  assign in_ready_o = (state_q == HS_RUN) && !(p_vld_q && p_last_q);
  assign acc = in_valid_i && in_ready_o;
  assign cur = (w_vld_q && w_addr_q == p_addr_q) ? w_data_q : rd_q;

  // address, write and next state
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    rd_addr = in_data_i.sample[SampleBits-1:0];
    we      = 1'b0;
    wa      = p_addr_q;
    wd      = (cur == CountMax) ? cur : cur + 1'b1;
    case (state_q)
      HS_RUN: begin
        if (p_vld_q) we = 1'b1;
        if (p_vld_q && p_last_q) begin
          state_d = HS_SCAN;
          ptr_d   = '0;
        end
      end
      HS_SCAN: begin
        rd_addr = ptr_q[SampleBits-1:0];
        ptr_d   = ptr_q + 1'b1;
        if (ptr_q == (SampleBits+1)'(NumBins - 1)) state_d = HS_SCAN_END;
      end
      HS_SCAN_END: state_d = HS_WAIT;
      HS_WAIT: begin
        state_d = HS_CLEAR;
        ptr_d   = '0;
      end
      HS_CLEAR: begin
        we    = 1'b1;
        wa    = ptr_q[SampleBits-1:0];
        wd    = '0;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (SampleBits+1)'(NumBins - 1) && !math_busy_i) state_d = HS_RUN;
        if (ptr_q == (SampleBits+1)'(NumBins - 1) && math_busy_i) ptr_d = ptr_q;
      end
      default: state_d = HS_RUN;
    endcase
  end

  // histogram memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= HS_CLEAR;
      ptr_q    <= '0;
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      p_addr_q <= '0;
      w_vld_q  <= 1'b0;
      w_addr_q <= '0;
      w_data_q <= '0;
      total_q  <= '0;
      max_q    <= '0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      p_vld_q  <= acc;
      if (acc) begin
        p_last_q <= in_data_i.last;
        p_addr_q <= in_data_i.sample[SampleBits-1:0];
        if (total_q != CountMax) total_q <= total_q + 1'b1;
      end
      w_vld_q  <= we;
      w_addr_q <= wa;
      w_data_q <= wd;
      // bins read in scan land in rd_q in the next cycle
      if (state_q == HS_RUN && p_vld_q && p_last_q) max_q <= '0;
      else if ((state_q == HS_SCAN && ptr_q != '0) || state_q == HS_SCAN_END)
        if (rd_q > max_q) max_q <= rd_q;
      if (state_q == HS_WAIT) total_q <= '0;
    end
  end

  assign req_o.start     = (state_q == HS_WAIT);
  assign req_o.max_count = max_q;
  assign req_o.total     = total_q;
endmodule

// ----- hw/rtl/mcv_math.sv -----
// ----------------------------------------------------------------------------
// mcv_math
// bit-serial divide, root and log2 for the final estimate
// ----------------------------------------------------------------------------
module mcv_math (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcv_pkg::math_req_t req_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output mcv_pkg::result_t   out_data_o,
  input  logic               out_ready_i
);
  import mcv_pkg::*;

  math_state_e state_q;
  logic [5:0]  cnt_q;
  logic [CountBits-1:0] maxc_q, den_q;
  logic [47:0] num_q, quo_q;
  logic [CountBits:0] rem_q;
  logic [24:0] phat_q, pu_q;
  logic [47:0] rad_q;
  logic [25:0] root_q;
  logic [49:0] srem_q;
  logic [57:0] prod_q;
  logic [31:0] y_q;
  logic [4:0]  n_q;
  logic [15:0] frac_q;
  logic        out_vld_q;
  result_t     res_q;

  logic [CountBits:0] rem_sh;
  logic [49:0] trial, srem_sh;
  logic [63:0] sq;
  logic [57:0] term_full;
  logic [25:0] pu_sum;

  // one restoring division step
  assign rem_sh = {rem_q[CountBits-1:0], num_q[47]};
  // one root step: two radicand bits per cycle
  assign srem_sh = {srem_q[47:0], rad_q[47:46]};
  assign trial   = {22'd0, root_q, 2'b01};
  assign sq      = 64'(y_q) * 64'(y_q);
  assign term_full = prod_q + 58'd536870912;
  assign pu_sum  = 26'(phat_q) + 26'(term_full[57:30]);

  assign busy_o      = (state_q != MS_IDLE) || out_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= MS_IDLE;
      out_vld_q <= 1'b0;
      cnt_q <= '0; maxc_q <= '0; den_q <= '0; num_q <= '0; quo_q <= '0;
      rem_q <= '0; phat_q <= '0; pu_q <= '0; rad_q <= '0; root_q <= '0;
      srem_q <= '0; prod_q <= '0; y_q <= '0; n_q <= '0; frac_q <= '0;
      res_q <= '0;
    end else begin
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      case (state_q)
        MS_IDLE: if (req_i.start) begin
          maxc_q <= req_i.max_count;
          if (req_i.total < 2) begin
            res_q     <= '{max_count: '0, p_hat: '0, p_upper: '0,
                           h_min: '0, status: ST_SHORT};
            out_vld_q <= 1'b1;
          end else begin
            // p_hat = max * 2^24 / L, 45 quotient bits
            den_q   <= req_i.total;
            num_q   <= {req_i.max_count, 27'd0};
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= 6'd45;
            state_q <= MS_DIV1;
          end
        end
        MS_DIV1, MS_DIV2: begin
          num_q <= num_q << 1;
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) begin
            if (state_q == MS_DIV1) state_q <= MS_MUL;
            else begin
              rad_q   <= (rem_sh >= {1'b0, den_q}) ? {quo_q[46:0], 1'b1}
                                                   : {quo_q[46:0], 1'b0};
              srem_q  <= '0;
              root_q  <= '0;
              cnt_q   <= 6'd24;
              state_q <= MS_SQRT;
            end
          end
        end
        MS_MUL: begin
          phat_q  <= (quo_q > 48'(OneQ24)) ? OneQ24 : quo_q[24:0];
          num_q   <= ((quo_q > 48'(OneQ24)) ? 48'd0
                      : 48'(quo_q[24:0]) * 48'(OneQ24 - quo_q[24:0]));
          // den_q still holds the sample count L
          den_q   <= den_q - 1'b1;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= 6'd48;
          state_q <= MS_DIV2;
        end
        MS_SQRT: begin
          rad_q <= rad_q << 2;
          if (srem_sh >= trial) begin
            srem_q <= srem_sh - trial;
            root_q <= {root_q[24:0], 1'b1};
          end else begin
            srem_q <= srem_sh;
            root_q <= {root_q[24:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) state_q <= MS_ZMUL;
        end
        MS_ZMUL: begin
          prod_q  <= 58'(root_q) * 58'(ZQ30);
          cnt_q   <= 6'd0;
          state_q <= MS_NORM;
        end
        MS_NORM: begin
          if (cnt_q == 6'd0) begin
            pu_q  <= (pu_sum > 26'(OneQ24)) ? OneQ24 : pu_sum[24:0];
            cnt_q <= 6'd1;
          end else if (pu_q == '0) begin
            res_q <= '{max_count: maxc_q, p_hat: phat_q, p_upper: pu_q,
                       h_min: EntMax, status: ST_OK};
            state_q <= MS_DONE;
          end else if (cnt_q == 6'd1) begin
            n_q   <= 5'd24;
            y_q   <= 32'(pu_q) << 6;
            cnt_q <= 6'd2;
          end else if (!y_q[30]) begin
            // one bit of normalization per cycle
            y_q <= y_q << 1;
            n_q <= n_q - 1'b1;
          end else begin
            frac_q  <= '0;
            cnt_q   <= 6'd16;
            state_q <= MS_LOG;
          end
        end
        MS_LOG: begin
          if (sq[61]) begin
            y_q    <= sq[62:31];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            y_q    <= sq[61:30];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) state_q <= MS_DONE;
        end
        MS_DONE: begin
          if (pu_q != '0)
            res_q <= '{max_count: maxc_q, p_hat: phat_q, p_upper: pu_q,
                       h_min: EntMax - {n_q, frac_q}, status: ST_OK};
          out_vld_q <= 1'b1;
          state_q   <= MS_IDLE;
        end
        default: state_q <= MS_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/most_common_value_entropy_estimator.sv -----
// ----------------------------------------------------------------------------
// most_common_value_entropy_estimator
// most common value min-entropy estimate over a run of samples
//
//   channel   dir   payload
//   in_if     sink  sample, last
//   out_if    src   max_count, p_hat, p_upper, h_min, status
//
// samples are taken one per cycle while input is ready; the histogram
// read-modify-write forwards the previous write. after last: the final
// write and a max scan over all bins, then serial division, root and log2.
// a clearing sweep over all bins after reset and after each run blocks
// input; input also waits while a result is still not taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module most_common_value_entropy_estimator (
  input logic clk_i,
  input logic rst_ni,
  mcv_if.sink   in_if,
  mcv_if.source out_if
);
  import mcv_pkg::*;

  math_req_t req;
  logic      busy;

  mcv_hist u_hist (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_data_i   (in_if.data),
    .in_ready_o  (in_if.ready),
    .req_o       (req),
    .math_busy_i (busy)
  );

  mcv_math u_math (
    .clk_i, .rst_ni,
    .req_i       (req),
    .busy_o      (busy),
    .out_valid_o (out_if.valid),
    .out_data_o  (out_if.data),
    .out_ready_i (out_if.ready)
  );

  `ASSERT_NEVER(a_start_busy, clk_i, rst_ni, req.start && busy)
  `ASSERT_PROP(a_status_zero, clk_i, rst_ni,
    (out_if.valid && out_if.data.status) |-> (out_if.data.p_upper == '0))
  `ASSERT_PROP(a_pu_ge_phat, clk_i, rst_ni,
    out_if.valid |-> (out_if.data.p_upper >= out_if.data.p_hat))
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the most common value estimator against a fixed-point predictor
//
// sample runs of random length and skew are streamed in over the input
// channel; each run's result is predicted when its last sample is accepted
// and compared field by field with the result taken from the output channel.
// sender gaps and receiver stalls vary by phase, including one long stall.
// ----------------------------------------------------------------------------
module testbench;
  import mcv_pkg::*;

  localparam int unsigned CycleLimit = 4000000;

  logic clk_i;
  logic rst_ni;

  mcv_if #(.T(sample_t)) in_if ();
  mcv_if #(.T(result_t)) out_if ();

  most_common_value_entropy_estimator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  // predictor state
  logic [CountBits-1:0] bin_count [NumBins];
  logic [CountBits-1:0] run_total;

  sample_t pending_samples[$];
  result_t expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned run_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // log2 in q8.16 by repeated squaring
  function automatic logic [63:0] log2_q8_16(logic [63:0] x);
    int unsigned msb;
    logic [63:0] y;
    logic [63:0] frac;
    msb = 0;
    frac = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    y = x << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        y = y >> 1;
      end
    end
    return (64'(msb) << 16) | frac;
  endfunction

  // count one sample; on last, close the run and predict its result
  task automatic count_sample(sample_t s);
    logic [63:0] maxc, total, phat, rad, root, term, pu, ent;
    result_t r;
    if (bin_count[s.sample] != CountMax) bin_count[s.sample]++;
    if (run_total != CountMax) run_total++;
    if (s.last) begin
      maxc = 0;
      total = 64'(run_total);
      for (int i = 0; i < NumBins; i++) begin
        if (64'(bin_count[i]) > maxc) maxc = 64'(bin_count[i]);
        bin_count[i] = '0;
      end
      run_total = '0;
      r = '0;
      if (total < 2) begin
        r.status = ST_SHORT;
      end else begin
        phat = (maxc << 24) / total;
        if (phat > 64'(OneQ24)) phat = 64'(OneQ24);
        rad = (phat * (64'(OneQ24) - phat)) / (total - 1);
        root = int_sqrt(rad);
        term = (root * 64'(ZQ30) + (64'd1 << 29)) >> 30;
        pu = phat + term;
        if (pu > 64'(OneQ24)) pu = 64'(OneQ24);
        if (pu == 0) ent = 64'd24 << 16;
        else ent = (64'd24 << 16) - log2_q8_16(pu);
        r.max_count = maxc[20:0];
        r.p_hat = phat[24:0];
        r.p_upper = pu[24:0];
        r.h_min = ent[20:0];
        r.status = ST_OK;
      end
      expected_results.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) count_sample(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_samples.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_if.data);
      end else begin
        want = expected_results.pop_front();
        if (out_if.data.max_count !== want.max_count ||
            out_if.data.p_hat !== want.p_hat ||
            out_if.data.p_upper !== want.p_upper ||
            out_if.data.h_min !== want.h_min ||
            out_if.data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected %p, got %p", result_count, want, out_if.data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_sample(logic [7:0] v, logic lst);
    sample_t s;
    s.sample = v;
    s.last = lst;
    pending_samples.push_back(s);
  endtask

  // one run of the given length with a skewed value distribution
  task automatic add_run(int unsigned len);
    logic [7:0] favored;
    int unsigned bias;
    favored = 8'($urandom);
    bias = $urandom_range(100);
    for (int unsigned i = 0; i < len; i++)
      add_sample(($urandom_range(99) < bias) ? favored : 8'($urandom), i == len - 1);
    run_count++;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned len;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    mismatch_count = 0;
    result_count = 0;
    run_count = 0;
    cycle_count = 0;
    run_total = '0;
    for (int i = 0; i < NumBins; i++) bin_count[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short runs, uniform runs, extremes of the sample field
    add_sample(8'h00, 1'b1);
    add_sample(8'hff, 1'b0);
    add_sample(8'hff, 1'b1);
    add_sample(8'h00, 1'b0);
    add_sample(8'hff, 1'b1);
    add_sample(8'h55, 1'b0);
    add_sample(8'haa, 1'b0);
    add_sample(8'h0f, 1'b0);
    add_sample(8'hf0, 1'b1);
    for (int i = 0; i < 8; i++) add_sample(8'h80, i == 7);
    add_sample(8'h7f, 1'b1);
    run_count = 6;
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 88 : 37) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 88 : 37) : 0;
      for (int k = 0; k < 270; k += len) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
        add_run(len);
      end
      if (phase == 0) begin
        // long stall while the sender keeps offering runs
        for (int r = 0; r < 4; r++) add_run($urandom_range(2, 10));
        hold_cycles = 3000;
      end
      wait_drained();
    end

    repeat (600) @(posedge clk_i);
    $display("%0d runs checked, %0d results, with varied sender gaps and receiver stalls",
             run_count, result_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_results.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
